// ===== hw/rtl/ips_patch_record_parser_macros.svh =====
// ----------------------------------------------------------------------------
// IPS patch record parser assertion macros
// Concurrent assertion wrappers clocked on clk_i; IPR_ASSERT is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IPS_PATCH_RECORD_PARSER_MACROS_SVH
`define IPS_PATCH_RECORD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// implication checked at every edge outside reset
`define IPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, but also checked while reset is asserted
`define IPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define IPR_ASSERT(lbl, prop, msg)
`define IPR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/ipr_pkg.sv =====
// ----------------------------------------------------------------------------
// IPS patch record parser package
// Field widths, result kinds, status codes and header constants.
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 25;
  localparam int unsigned RunW   = 16;
  localparam int unsigned LenW   = 32;
  localparam int unsigned OffW   = 24;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  // result kinds
  localparam logic [KindW-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KindW-1:0] KIND_FILL   = 2'd1;
  localparam logic [KindW-1:0] KIND_FINISH = 2'd2;

  // finish status codes
  localparam logic [StatW-1:0] ST_OK            = 2'd0;
  localparam logic [StatW-1:0] ST_BROKEN        = 2'd1;
  localparam logic [StatW-1:0] ST_DAMAGED       = 2'd2;
  localparam logic [StatW-1:0] ST_NOT_SHRINKING = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PATCH_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_SIZE  = 1'b1;

  localparam logic [OffW-1:0] EOF_MARK  = 24'h454F46;
  localparam logic [LenW-1:0] MIN_PATCH = 32'd8;
  localparam logic [LenW-1:0] HDR_LEN   = 32'd5;
  // size (2) + at least one more byte + EOF mark (3), counted after the offset
  localparam int signed RecMin = 2 + 1 + 3;

  // "PATCH" signature
  function automatic logic [ByteW-1:0] hdr_byte(input logic [2:0] idx);
    logic [ByteW-1:0] r;
    case (idx)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h41;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h43;
      3'd4:    r = 8'h48;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ipr_stream_if.sv =====
// ----------------------------------------------------------------------------
// IPS patch record parser channels
// Valid/ready channels for patch bytes in and parser results out.
// ----------------------------------------------------------------------------
interface ipr_byte_if import ipr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] patch_byte;

  modport source (output valid, output patch_byte, input ready);
  modport sink   (input valid, input patch_byte, output ready);
endinterface

interface ipr_result_if import ipr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AddrW-1:0] write_address;
  logic [RunW-1:0]  run_length;
  logic [ByteW-1:0] data_value;
  logic [AddrW-1:0] final_size;
  logic [StatW-1:0] status;

  modport source (output valid, output kind, output write_address, output run_length,
                  output data_value, output final_size, output status, input ready);
  modport sink   (input valid, input kind, input write_address, input run_length,
                  input data_value, input final_size, input status, output ready);
endinterface

// ===== hw/rtl/ips_patch_record_parser.sv =====
// ----------------------------------------------------------------------------
// IPS patch record parser
// Parses an IPS patch byte stream into byte writes, fill runs and a finish.
// ----------------------------------------------------------------------------
//  channel    dir  handshake            word
//  patch_i    in   valid/ready          one patch byte
//  result_o   out  valid/ready          write, fill or finish record
//  cfg_*_i    in   write enable only    patch length, source size
//
//  one byte accepted per cycle unless the result stalls; a result reaches the output
//  through the input register, then the parse step into the result register
//  the parse step is one 34-bit remaining-length subtract and compare
//  rst_ni clears the parser to expect the header, the input valid and the result register to zero
//  a stalled result holds the byte stage; the input still takes one word
//  after the finish every byte is taken and dropped
// ----------------------------------------------------------------------------
`include "ips_patch_record_parser_macros.svh"

module ips_patch_record_parser import ipr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ipr_byte_if.sink            patch_i,
  ipr_result_if.source        result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_OFF0, PH_OFF1, PH_OFF2, PH_SIZE0, PH_SIZE1, PH_RLEN0, PH_RLEN1,
    PH_RVAL, PH_DATA, PH_TRUNC0, PH_TRUNC1, PH_TRUNC2, PH_DONE
  } phase_e;

  // configuration
  logic [LenW-1:0]  patch_len_q;
  logic [AddrW-1:0] src_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_len_q <= '0;
      src_size_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATCH_LENGTH: patch_len_q <= cfg_data_i;
        CFG_SOURCE_SIZE:  src_size_q  <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             adv;

  assign out_free      = !result_o.valid || result_o.ready;
  assign adv           = in_vld_q && out_free;
  assign patch_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (patch_i.ready) begin
      in_vld_q <= patch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (patch_i.valid && patch_i.ready) begin
      in_byte_q <= patch_i.patch_byte;
    end
  end

  // parser state
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  consumed_q, consumed_d;
  logic [OffW-1:0]  acc_q, acc_d;
  logic [OffW-1:0]  rec_off_q, rec_off_d;
  logic [RunW-1:0]  rec_cnt_q, rec_cnt_d;
  logic [OffW-1:0]  prev_off_q, prev_off_d;
  logic [AddrW-1:0] high_end_q, high_end_d;
  logic [StatW-1:0] pend_st_q, pend_st_d;

  // result register
  logic             out_vld_q;
  logic [KindW-1:0] out_kind_q;
  logic [AddrW-1:0] out_addr_q;
  logic [RunW-1:0]  out_run_q;
  logic [ByteW-1:0] out_val_q;
  logic [AddrW-1:0] out_fsize_q;
  logic [StatW-1:0] out_st_q;

  logic             emit;
  logic [KindW-1:0] r_kind;
  logic [AddrW-1:0] r_addr;
  logic [RunW-1:0]  r_run;
  logic [AddrW-1:0] r_fsize;
  logic [StatW-1:0] r_st;

  logic [ByteW-1:0]  b;
  logic signed [33:0] rem_s;
  logic signed [33:0] need_s;
  logic [OffW-1:0]   field24;
  logic [RunW-1:0]   field16;
  logic [RunW-1:0]   cnt_inc;
  logic [AddrW-1:0]  end_sum;
  logic [AddrW-1:0]  grown;
  logic [StatW-1:0]  trunc_st;

  assign b       = in_byte_q;
  // bytes left after this one, may go negative
  assign rem_s   = $signed({2'b00, patch_len_q} - {2'b00, consumed_q} - 34'd1);
  assign field24 = {acc_q[15:0], b};
  assign field16 = {acc_q[7:0], b};
  assign need_s  = $signed({18'd0, field16} + 34'd3);
  assign cnt_inc = rec_cnt_q + 16'd1;
  assign end_sum = {1'b0, rec_off_q} + {9'd0, (phase_q == PH_SIZE1) ? field16 : rec_cnt_q};
  assign grown   = (high_end_q > src_size_q) ? high_end_q : src_size_q;

  always_comb begin
    trunc_st = pend_st_q;
    if (pend_st_q == ST_OK && {1'b0, field24} >= src_size_q) begin
      trunc_st = ST_NOT_SHRINKING;
    end
    if (rem_s != 34'sd0) begin
      trunc_st = ST_DAMAGED;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    consumed_d = consumed_q;
    acc_d      = acc_q;
    rec_off_d  = rec_off_q;
    rec_cnt_d  = rec_cnt_q;
    prev_off_d = prev_off_q;
    high_end_d = high_end_q;
    pend_st_d  = pend_st_q;
    emit       = 1'b0;
    r_kind     = KIND_FINISH;
    r_addr     = '0;
    r_run      = '0;
    r_fsize    = '0;
    r_st       = ST_OK;

    if (phase_q != PH_DONE) begin
      consumed_d = consumed_q + 32'd1;
    end

    unique case (phase_q)
      PH_HEADER: begin
        if (patch_len_q < MIN_PATCH || consumed_q >= HDR_LEN ||
            b != hdr_byte(consumed_q[2:0])) begin
          emit = 1'b1;
          r_st = ST_BROKEN;
        end else if (consumed_q == HDR_LEN - 32'd1) begin
          phase_d = PH_OFF0;
        end
      end
      PH_OFF0, PH_SIZE0, PH_RLEN0, PH_TRUNC0: begin
        acc_d = {16'd0, b};
        unique case (phase_q)
          PH_OFF0:  phase_d = PH_OFF1;
          PH_SIZE0: phase_d = PH_SIZE1;
          PH_RLEN0: phase_d = PH_RLEN1;
          default:  phase_d = PH_TRUNC1;
        endcase
      end
      PH_OFF1, PH_TRUNC1: begin
        acc_d   = field24;
        phase_d = (phase_q == PH_OFF1) ? PH_OFF2 : PH_TRUNC2;
      end
      PH_OFF2: begin
        acc_d = '0;
        if (field24 == EOF_MARK) begin
          if (rem_s == 34'sd3) begin
            phase_d = PH_TRUNC0;
          end else begin
            emit    = 1'b1;
            r_fsize = grown;
            r_st    = (rem_s == 34'sd0) ? pend_st_q : ST_DAMAGED;
          end
        end else begin
          if (field24 < prev_off_q) begin
            pend_st_d = ST_DAMAGED;
          end
          prev_off_d = field24;
          rec_off_d  = field24;
          if (rem_s < 34'(RecMin)) begin
            emit = 1'b1;
            r_st = ST_BROKEN;
          end else begin
            phase_d = PH_SIZE0;
          end
        end
      end
      PH_SIZE1: begin
        if (field16 == '0) begin
          if (rem_s < 34'(RecMin)) begin
            emit = 1'b1;
            r_st = ST_BROKEN;
          end else begin
            acc_d   = '0;
            phase_d = PH_RLEN0;
          end
        end else if (rem_s < need_s) begin
          emit = 1'b1;
          r_st = ST_BROKEN;
        end else begin
          if (end_sum > high_end_q) begin
            high_end_d = end_sum;
          end
          acc_d     = {8'd0, field16};
          rec_cnt_d = '0;
          phase_d   = PH_DATA;
        end
      end
      PH_RLEN1: begin
        rec_cnt_d = field16;
        phase_d   = PH_RVAL;
      end
      PH_RVAL: begin
        emit = 1'b1;
        if (rec_cnt_q == '0) begin
          r_st = ST_BROKEN;
        end else begin
          if (end_sum > high_end_q) begin
            high_end_d = end_sum;
          end
          r_kind  = KIND_FILL;
          r_addr  = {1'b0, rec_off_q};
          r_run   = rec_cnt_q;
          phase_d = PH_OFF0;
        end
      end
      PH_DATA: begin
        emit      = 1'b1;
        r_kind    = KIND_WRITE;
        r_addr    = end_sum;
        rec_cnt_d = cnt_inc;
        if (cnt_inc == '0 || {8'd0, cnt_inc} >= acc_q) begin
          phase_d = PH_OFF0;
        end
      end
      PH_TRUNC2: begin
        emit    = 1'b1;
        r_fsize = {1'b0, field24};
        r_st    = trunc_st;
      end
      PH_DONE: ;
      default: phase_d = PH_DONE;
    endcase

    // any finish closes the stream
    if (emit && r_kind == KIND_FINISH) begin
      phase_d   = PH_DONE;
      pend_st_d = r_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      consumed_q  <= '0;
      acc_q       <= '0;
      rec_off_q   <= '0;
      rec_cnt_q   <= '0;
      prev_off_q  <= '0;
      high_end_q  <= '0;
      pend_st_q   <= ST_OK;
      out_vld_q   <= 1'b0;
      out_kind_q  <= KIND_WRITE;
      out_addr_q  <= '0;
      out_run_q   <= '0;
      out_val_q   <= '0;
      out_fsize_q <= '0;
      out_st_q    <= ST_OK;
    end else begin
      if (adv) begin
        phase_q    <= phase_d;
        consumed_q <= consumed_d;
        acc_q      <= acc_d;
        rec_off_q  <= rec_off_d;
        rec_cnt_q  <= rec_cnt_d;
        prev_off_q <= prev_off_d;
        high_end_q <= high_end_d;
        pend_st_q  <= pend_st_d;
      end
      if (adv && emit) begin
        out_vld_q   <= 1'b1;
        out_kind_q  <= r_kind;
        out_addr_q  <= r_addr;
        out_run_q   <= r_run;
        out_val_q   <= (r_kind == KIND_FINISH) ? '0 : b;
        out_fsize_q <= r_fsize;
        out_st_q    <= r_st;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.kind          = out_kind_q;
  assign result_o.write_address = out_addr_q;
  assign result_o.run_length    = out_run_q;
  assign result_o.data_value    = out_val_q;
  assign result_o.final_size    = out_fsize_q;
  assign result_o.status        = out_st_q;

  `IPR_ASSERT(a_done_silent, (adv && phase_q == PH_DONE) |-> !emit, "result after finish")
  `IPR_ASSERT(a_finish_closes, (adv && emit && r_kind == KIND_FINISH) |=> phase_q == PH_DONE, "finish did not close stream")
  `IPR_ASSERT(a_count_step, (adv && phase_q != PH_DONE) |=> consumed_q == $past(consumed_q) + 32'd1, "byte count slip")
  `IPR_ASSERT(a_fill_nonzero, (out_vld_q && out_kind_q == KIND_FILL) |-> out_run_q != '0, "fill run of zero")
  `IPR_ASSERT_ALWAYS(a_ready_when_free, (rst_ni && out_free) |-> patch_i.ready, "input blocked with free output")

endmodule
